FILE: rtl/tmhq_pkg.sv
// Package for the three-ary min-heap queue: beat types, datapath opcodes and status codes.
package tmhq_pkg;

    // Fixed widths of the beat fields.
    localparam int unsigned PRIO_W   = 32;
    localparam int unsigned TAG_W    = 16;
    localparam int unsigned STATUS_W = 2;
    // Widest internal priority or tag that the store may hold.
    localparam int unsigned MAX_W    = 64;

    // Command codes of an input beat.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes of a result beat.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Datapath operations issued by the controller.
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE     = 4'd0;
    localparam t_op OP_INSERT   = 4'd1;
    localparam t_op OP_FULL     = 4'd2;
    localparam t_op OP_EMPTY    = 4'd3;
    localparam t_op OP_RM_START = 4'd4;
    localparam t_op OP_RM_ROOT  = 4'd5;
    localparam t_op OP_RM_LAST  = 4'd6;
    localparam t_op OP_UP_READ  = 4'd7;
    localparam t_op OP_UP_SWAP  = 4'd8;
    localparam t_op OP_PLACE    = 4'd9;
    localparam t_op OP_DN_SCAN  = 4'd10;
    localparam t_op OP_DN_MOVE  = 4'd11;

    // Input beat.
    typedef struct packed {
        logic                     command;
        logic signed [PRIO_W-1:0] priority_req;
        logic [TAG_W-1:0]         payload;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [PRIO_W-1:0] out_priority;
        logic [TAG_W-1:0]         out_payload;
    } t_out_beat;

    // Controller to datapath.
    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_ctl;

    // Datapath to controller.
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic at_root;
        logic up_less;
        logic scan_done;
        logic best_stay;
    } t_stat;

endpackage

FILE: rtl/tmhq_ctrl.sv
// Sequencer of the heap queue: walks insert and remove operations and owns the handshakes.
module tmhq_ctrl
    import tmhq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_command,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output logic  o_out_valid,
    output t_ctl  o_ctl
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_RD   = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_RM_ROOT = 3'd3;
    localparam logic [2:0] S_RM_LAST = 3'd4;
    localparam logic [2:0] S_DN_SCAN = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // The output register can take a new beat when it is empty or being drained.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and datapath operation.
    always_comb begin
        n_state        = r_state;
        o_ctl.op       = OP_NONE;
        o_ctl.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_command == CMD_INSERT) begin
                        if (i_stat.count_full) begin
                            o_ctl.op = OP_FULL;
                            n_state  = S_DONE;
                        end else begin
                            o_ctl.op = OP_INSERT;
                            n_state  = S_UP_RD;
                        end
                    end else begin
                        if (i_stat.count_zero) begin
                            o_ctl.op = OP_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            o_ctl.op = OP_RM_START;
                            n_state  = S_RM_ROOT;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (i_stat.at_root) begin
                    o_ctl.op = OP_PLACE;
                    n_state  = S_DONE;
                end else begin
                    o_ctl.op = OP_UP_READ;
                    n_state  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_less) begin
                    o_ctl.op = OP_UP_SWAP;
                    n_state  = S_UP_RD;
                end else begin
                    o_ctl.op = OP_PLACE;
                    n_state  = S_DONE;
                end
            end
            S_RM_ROOT: begin
                o_ctl.op = OP_RM_ROOT;
                n_state  = S_RM_LAST;
            end
            S_RM_LAST: begin
                o_ctl.op = OP_RM_LAST;
                n_state  = i_stat.count_zero ? S_DONE : S_DN_SCAN;
            end
            S_DN_SCAN: begin
                if (!i_stat.scan_done) begin
                    o_ctl.op = OP_DN_SCAN;
                end else if (i_stat.best_stay) begin
                    o_ctl.op = OP_PLACE;
                    n_state  = S_DONE;
                end else begin
                    o_ctl.op = OP_DN_MOVE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid follows loads and drains.
    always_comb begin
        n_out_valid = r_out_valid;
        priority if (o_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/tmhq_datapath.sv
// Datapath of the heap queue: entry store, moving entry, sift indexes, compares and result.
module tmhq_datapath
    import tmhq_pkg::*;
#(
    parameter int unsigned DEPTH         = 64,
    parameter int unsigned PRIORITY_BITS = 32,
    parameter int unsigned TAG_BITS      = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl      i_ctl,
    input  t_in_beat  i_in,
    output t_stat     o_stat,
    output t_out_beat o_out
);

    localparam int unsigned AW  = $clog2(DEPTH);
    localparam int unsigned CW  = $clog2(DEPTH + 1);
    localparam int unsigned CHW = AW + 2;
    localparam int unsigned EW  = PRIORITY_BITS + TAG_BITS;
    // Parent index by multiplying with a reciprocal of three.
    localparam int unsigned RS  = AW + 1;
    localparam int unsigned PW  = AW + RS;
    localparam logic [RS-1:0] RECIP = RS'(((2 ** RS) + 2) / 3);

    logic [EW-1:0]  r_mem [DEPTH];
    logic [EW-1:0]  r_rd_data;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  r_pos;
    logic [EW-1:0]  r_ent;
    logic [EW-1:0]  r_best_ent;
    logic [AW-1:0]  r_best_idx;
    logic [CHW-1:0] r_child;
    logic [1:0]     r_issued;
    logic           r_pend;
    logic [AW-1:0]  r_cmp_idx;
    t_out_beat      r_res;
    t_out_beat      r_out;

    logic [EW-1:0]  in_ent;
    logic [MAX_W-1:0] in_prio_ext;
    logic [MAX_W-1:0] in_tag_ext;
    logic [MAX_W-1:0] rd_prio_ext;
    logic [MAX_W-1:0] rd_tag_ext;
    logic [AW-1:0]  pos_m1;
    logic [PW-1:0]  par_prod;
    logic [AW-1:0]  parent;
    logic [CHW-1:0] move_child;
    logic           can_issue;
    logic           up_less;
    logic           scan_less;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [EW-1:0]  wdata;
    logic           re;
    logic [AW-1:0]  raddr;

    // New entry: priority and tag cut or zero-extended to the stored widths.
    assign in_prio_ext = MAX_W'(unsigned'(i_in.priority_req));
    assign in_tag_ext  = MAX_W'(i_in.payload);
    assign in_ent      = {in_prio_ext[PRIORITY_BITS-1:0], in_tag_ext[TAG_BITS-1:0]};

    // Root entry widened before it is cut to the result fields.
    assign rd_prio_ext = MAX_W'(r_rd_data[EW-1:TAG_BITS]);
    assign rd_tag_ext  = MAX_W'(r_rd_data[TAG_BITS-1:0]);

    // Parent of the current position, (pos - 1) / 3.
    assign pos_m1   = r_pos - AW'(1);
    assign par_prod = PW'(pos_m1) * PW'(RECIP);
    assign parent   = par_prod[PW-1:RS];

    // First child of the chosen child, 3 * index + 1.
    assign move_child = (CHW'(r_best_idx) << 1) + CHW'(r_best_idx) + CHW'(1);

    // Signed compares on stored priorities.
    assign up_less   = $signed(r_ent[EW-1:TAG_BITS]) < $signed(r_rd_data[EW-1:TAG_BITS]);
    assign scan_less = $signed(r_rd_data[EW-1:TAG_BITS])
                     < $signed(r_best_ent[EW-1:TAG_BITS]);

    // A child is read while fewer than three were read and it lies inside the heap.
    assign can_issue = (r_issued != 2'd3) && (r_child < CHW'(r_count));

    // Status to the controller.
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_full = (r_count == CW'(DEPTH));
    assign o_stat.at_root    = (r_pos == '0);
    assign o_stat.up_less    = up_less;
    assign o_stat.scan_done  = !can_issue && !r_pend;
    assign o_stat.best_stay  = (r_best_idx == r_pos);
    assign o_out             = r_out;

    // Store port selection.
    always_comb begin
        we    = 1'b0;
        waddr = r_pos;
        wdata = r_ent;
        re    = 1'b0;
        raddr = '0;
        unique case (i_ctl.op)
            OP_RM_START: begin
                re    = 1'b1;
                raddr = '0;
            end
            OP_RM_ROOT: begin
                re    = 1'b1;
                raddr = r_count[AW-1:0];
            end
            OP_UP_READ: begin
                re    = 1'b1;
                raddr = parent;
            end
            OP_UP_SWAP: begin
                we    = 1'b1;
                wdata = r_rd_data;
            end
            OP_PLACE: begin
                we    = 1'b1;
            end
            OP_DN_SCAN: begin
                re    = can_issue;
                raddr = r_child[AW-1:0];
            end
            OP_DN_MOVE: begin
                we    = 1'b1;
                wdata = r_best_ent;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // Entry store with registered read.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.op == OP_INSERT) begin
            r_count <= r_count + CW'(1);
        end else if (i_ctl.op == OP_RM_START) begin
            r_count <= r_count - CW'(1);
        end
    end

    // Scan pipeline flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_ctl.op == OP_DN_SCAN) begin
            r_pend <= can_issue;
        end else if (i_ctl.op == OP_RM_LAST || i_ctl.op == OP_DN_MOVE) begin
            r_pend <= 1'b0;
        end
    end

    // Sift registers and result.
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_INSERT: begin
                r_ent              <= in_ent;
                r_pos              <= r_count[AW-1:0];
                r_res.status       <= ST_DONE;
                r_res.out_priority <= '0;
                r_res.out_payload  <= '0;
            end
            OP_FULL: begin
                r_res.status       <= ST_FULL;
                r_res.out_priority <= '0;
                r_res.out_payload  <= '0;
            end
            OP_EMPTY: begin
                r_res.status       <= ST_EMPTY;
                r_res.out_priority <= '0;
                r_res.out_payload  <= '0;
            end
            OP_RM_ROOT: begin
                r_res.status       <= ST_DONE;
                r_res.out_priority <= rd_prio_ext[PRIO_W-1:0];
                r_res.out_payload  <= rd_tag_ext[TAG_W-1:0];
            end
            OP_RM_LAST: begin
                // The last entry becomes the moving entry at the root.
                r_ent      <= r_rd_data;
                r_best_ent <= r_rd_data;
                r_pos      <= '0;
                r_best_idx <= '0;
                r_child    <= CHW'(1);
                r_issued   <= '0;
            end
            OP_UP_SWAP: begin
                r_pos <= parent;
            end
            OP_DN_SCAN: begin
                // Compare the child read last cycle while the next one is read.
                if (r_pend && scan_less) begin
                    r_best_ent <= r_rd_data;
                    r_best_idx <= r_cmp_idx;
                end
                if (can_issue) begin
                    r_cmp_idx <= r_child[AW-1:0];
                    r_child   <= r_child + CHW'(1);
                    r_issued  <= r_issued + 2'd1;
                end
            end
            OP_DN_MOVE: begin
                // The smaller child moves up; the next level starts at its slot.
                r_pos      <= r_best_idx;
                r_best_ent <= r_ent;
                r_child    <= move_child;
                r_issued   <= '0;
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
        if (i_ctl.out_load) begin
            r_out <= r_res;
        end
    end

endmodule

FILE: rtl/ternary_min_heap_queue.sv
// Top level of the three-ary min-heap priority queue.
//
// Input beats on i_in carry a command (insert or remove), a signed priority and
// a payload tag; each input beat yields exactly one result beat on o_out with a
// status, and for a successful remove the root's priority and tag.
// Both channels use valid and stall; a beat moves when valid is high and stall
// is low. One operation is in flight at a time: o_in_stall is high from the
// cycle after acceptance until the result has been moved into the output
// register, which then holds it while the receiver stalls.
// An operation runs through the controller states in turn: a full insert or an
// empty remove goes straight to the result; an insert reads and compares one
// parent per level moved, ending at the root or at a parent that is not larger;
// a remove reads the root and the last entry and, unless that was the only
// entry, scans the children of each position on the way down and moves the
// smallest child up until no child is smaller.
// The next input beat can be accepted at the same edge that can first move
// the result beat. A stalled output delays only the hand-over of the next
// result into the output register. Reset empties the queue by clearing the
// entry count; there is no clearing pass over the store.
module ternary_min_heap_queue
    import tmhq_pkg::*;
#(
    parameter int unsigned DEPTH         = 64,
    parameter int unsigned PRIORITY_BITS = 32,
    parameter int unsigned TAG_BITS      = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    t_ctl  ctl;
    t_stat stat;

    // Operation sequencer.
    tmhq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_command (i_in.command),
        .i_out_stall  (i_out_stall),
        .i_stat       (stat),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_ctl        (ctl)
    );

    // Store, sift logic and result registers.
    tmhq_datapath #(
        .DEPTH         (DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .TAG_BITS      (TAG_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_in    (i_in),
        .o_stat  (stat),
        .o_out   (o_out)
    );

endmodule

FILE: verif/tb_ternary_min_heap_queue.sv
// Self-checking testbench for the three-ary min-heap priority queue.
`timescale 1ns / 1ps

module tb_ternary_min_heap_queue;
    import tmhq_pkg::*;

    localparam int HEAP_DEPTH = 64;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;

    ternary_min_heap_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    // Shadow copy of the heap that predicts every result beat.
    logic signed [PRIO_W-1:0] heap_prio [HEAP_DEPTH];
    logic [TAG_W-1:0]         heap_tag [HEAP_DEPTH];
    int                       heap_count = 0;

    t_in_beat  pending_beats [$];
    t_out_beat expected_results [$];
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        mismatches = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void shadow_exchange(int a, int b);
        logic signed [PRIO_W-1:0] p;
        logic [TAG_W-1:0]         t;
        p = heap_prio[a];
        heap_prio[a] = heap_prio[b];
        heap_prio[b] = p;
        t = heap_tag[a];
        heap_tag[a] = heap_tag[b];
        heap_tag[b] = t;
    endfunction

    // Applies one command to the shadow heap and returns the result beat it causes.
    function automatic t_out_beat heap_apply(t_in_beat beat);
        t_out_beat res;
        int        pos;
        int        up;
        int        best;
        int        child;
        bit        settled;
        res = '0;
        res.status = ST_DONE;
        if (beat.command == CMD_INSERT) begin
            if (heap_count >= HEAP_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = heap_count;
                heap_prio[pos] = beat.priority_req;
                heap_tag[pos] = beat.payload;
                heap_count++;
                settled = 1'b0;
                // Sift up until the parent is not larger.
                while (pos > 0 && !settled) begin
                    up = (pos - 1) / 3;
                    if (heap_prio[pos] < heap_prio[up]) begin
                        shadow_exchange(pos, up);
                        pos = up;
                    end else begin
                        settled = 1'b1;
                    end
                end
            end
        end else begin
            if (heap_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.out_priority = heap_prio[0];
                res.out_payload = heap_tag[0];
                heap_count--;
                heap_prio[0] = heap_prio[heap_count];
                heap_tag[0] = heap_tag[heap_count];
                pos = 0;
                settled = 1'b0;
                // Sift down; strict less-than keeps the leftmost of equal children.
                while (!settled) begin
                    best = pos;
                    for (int k = 1; k <= 3; k++) begin
                        child = 3 * pos + k;
                        if (child < heap_count && heap_prio[child] < heap_prio[best]) begin
                            best = child;
                        end
                    end
                    if (best == pos) begin
                        settled = 1'b1;
                    end else begin
                        shadow_exchange(pos, best);
                        pos = best;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic t_in_beat make_insert(logic signed [PRIO_W-1:0] p, logic [TAG_W-1:0] t);
        t_in_beat b;
        b.command = CMD_INSERT;
        b.priority_req = p;
        b.payload = t;
        return b;
    endfunction

    // The priority and tag of a remove are ignored, but they still get random bits.
    function automatic t_in_beat make_remove();
        t_in_beat b;
        b.command = CMD_REMOVE;
        b.priority_req = $urandom;
        b.payload = TAG_W'($urandom);
        return b;
    endfunction

    // Wide values, a narrow band that forces ties, both extremes, a 16-bit range.
    function automatic logic signed [PRIO_W-1:0] rand_priority();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45) begin
            return $urandom;
        end else if (roll < 75) begin
            return $signed($urandom_range(8)) - 4;
        end else if (roll < 85) begin
            return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        end
        return $signed({{16{1'b0}}, 16'($urandom)}) - 32768;
    endfunction

    function automatic t_in_beat rand_insert();
        return make_insert(rand_priority(), TAG_W'($urandom));
    endfunction

    // Runs that lean toward filling, toward draining, or are evenly mixed.
    task automatic queue_runs(int n);
        int added;
        int run_len;
        int insert_pct;
        added = 0;
        while (added < n) begin
            case ($urandom_range(2))
                0: insert_pct = 85;
                1: insert_pct = 15;
                default: insert_pct = 50;
            endcase
            run_len = $urandom_range(40, 8);
            repeat (run_len) begin
                if ($urandom_range(99) < insert_pct) begin
                    pending_beats.push_back(rand_insert());
                end else begin
                    pending_beats.push_back(make_remove());
                end
                added++;
            end
        end
    endtask

    // Fill past the top so inserts are dropped, then drain past the bottom.
    task automatic queue_fill_drain();
        repeat (HEAP_DEPTH + 4) pending_beats.push_back(rand_insert());
        repeat (HEAP_DEPTH + 4) pending_beats.push_back(make_remove());
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Input driver: a beat holds while stalled, and the next one follows on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(heap_apply(in_beat));
            end
            if (!in_valid || !in_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    in_beat <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result monitor: compares each accepted beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat: status %0d prio %0d tag %h",
                         $realtime, out_beat.status, out_beat.out_priority,
                         out_beat.out_payload);
                mismatches++;
            end else begin
                if (out_beat.status !== expected_results[0].status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d", $realtime,
                             expected_results[0].status, out_beat.status);
                    mismatches++;
                end
                if (out_beat.out_priority !== expected_results[0].out_priority) begin
                    $display("%0t: priority mismatch: expected %0d actual %0d", $realtime,
                             expected_results[0].out_priority, out_beat.out_priority);
                    mismatches++;
                end
                if (out_beat.out_payload !== expected_results[0].out_payload) begin
                    $display("%0t: payload mismatch: expected %h actual %h", $realtime,
                             expected_results[0].out_payload, out_beat.out_payload);
                    mismatches++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    // Stimulus sequence, one traffic phase after another.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats: empty remove, extremes, signs, and a run of equal priorities.
        pending_beats.push_back(make_remove());
        pending_beats.push_back(make_insert(32'sh7fff_ffff, 16'hffff));
        pending_beats.push_back(make_insert(32'sh8000_0000, 16'h0000));
        pending_beats.push_back(make_insert(32'sd0, 16'h1234));
        pending_beats.push_back(make_insert(-32'sd1, 16'h0001));
        pending_beats.push_back(make_insert(32'sd1, 16'h0002));
        pending_beats.push_back(make_insert(32'sd5, 16'h000a));
        pending_beats.push_back(make_insert(32'sd5, 16'h000b));
        pending_beats.push_back(make_insert(32'sd5, 16'h000c));
        pending_beats.push_back(make_insert(32'sd5, 16'h000d));
        repeat (10) pending_beats.push_back(make_remove());

        // No idling on either side.
        queue_fill_drain();
        queue_runs(30);
        wait_drained();

        // Sender idle most of the time.
        idle_pct = 60;
        queue_runs(130);
        wait_drained();

        // Receiver stalling most of the time.
        idle_pct = 0;
        stall_pct = 60;
        queue_runs(130);
        wait_drained();

        // Light idling on both sides, with another pass through full and empty.
        idle_pct = 7;
        stall_pct = 7;
        queue_fill_drain();
        queue_runs(30);
        wait_drained();

        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_ternary_min_heap_queue passed");
        end else begin
            $display("tb_ternary_min_heap_queue failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5ms;
        $display("tb_ternary_min_heap_queue failed");
        $finish;
    end

endmodule
